// ----- hdl/swpb_pkg.sv -----
package swpb_pkg;

  localparam int BAND_BITS = 7;
  localparam logic [BAND_BITS-1:0] BAND_RESET = 7'd10;

  // floor(x / 200) = floor(floor(x / 8) / 25); the divide by 25 is a reciprocal
  // multiply, exact for floor(x / 8) below 43690
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_RECIP_BITS = 16;
  localparam logic [DIV_RECIP_BITS-1:0] DIV_RECIP = 16'd41944;
  localparam int DIV_SHIFT = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_DIV,
    ST_GRP,
    ST_OUT
  } swpb_state_t;

  typedef struct packed {
    logic upd;
    logic del_en;
  } swpb_ctl_t;

endpackage

// ----- hdl/swpb_ifs.sv -----
interface swpb_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swpb_out_if #(parameter int SAMPLE_BITS = 10, parameter int COUNT_BITS = 7);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] lower_bound;
  logic [SAMPLE_BITS-1:0] upper_bound;
  logic [COUNT_BITS-1:0]  fill_count;
  logic                   window_full;
  modport source (output valid, output lower_bound, output upper_bound,
                  output fill_count, output window_full, input ready);
  modport sink (input valid, input lower_bound, input upper_bound,
                input fill_count, input window_full, output ready);
endinterface

interface swpb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swpb_pkg::BAND_BITS-1:0] band_percent;
  modport source (output valid, output band_percent, input ready);
  modport sink (input valid, input band_percent, output ready);
endinterface

// ----- hdl/sliding_window_percentile_bounds.sv -----
// channel  dir  payload                                              handshake
// in_ch    in   sample                                               valid/ready
// out_ch   out  lower_bound, upper_bound, fill_count, window_full    valid/ready
// cfg_ch   in   band_percent                                         valid/ready
//
// Each sample passes through these steps from accept to result: the cell row
// deletes the oldest value and inserts the new one, then a multiply, a
// reciprocal divide, the readout tree, and the output load.
// A new sample is taken only in the idle state, once the last one has been loaded.
// rst_n is synchronous: empties the window and sets band_percent to 10.
// A new sample is taken while the last result waits; the pipe holds at the
// output load until out_ch is free.
module sliding_window_percentile_bounds #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  swpb_in_if.sink         in_ch,
  swpb_out_if.source      out_ch,
  swpb_cfg_if.sink        cfg_ch
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PRD_W = CNT_W + swpb_pkg::BAND_BITS;
  localparam int SHF_W = PRD_W - swpb_pkg::DIV_PRE_SHIFT;
  localparam int Q_W   = SHF_W + swpb_pkg::DIV_RECIP_BITS;

  swpb_pkg::swpb_state_t state_r, state_nxt;
  swpb_pkg::swpb_ctl_t   ctl;

  logic [swpb_pkg::BAND_BITS-1:0] band_r;
  logic [SAMPLE_BITS-1:0]         sample_r;
  logic [SAMPLE_BITS-1:0]         ov_r;
  logic [SAMPLE_BITS-1:0]         ring_mem [WINDOW_DEPTH];
  logic [IDX_W-1:0]               oldest_r, oldest_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W:0]                 slot_sum;
  logic [IDX_W-1:0]               wr_slot;
  logic                           full;
  logic [PRD_W-1:0]               prod_r;
  logic [Q_W-1:0]                 quot;
  logic [IDX_W-1:0]               lo_nxt;
  logic [IDX_W-1:0]               lo_r, hi_r;
  logic [SAMPLE_BITS-1:0]         lo_val, hi_val;
  logic                           out_valid_r;
  logic                           out_free;
  logic                           mul_en, div_en, out_load;

  assign full     = (cnt_r == CNT_W'(WINDOW_DEPTH));
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swpb_pkg::ST_IDLE: if (in_ch.valid) state_nxt = swpb_pkg::ST_UPD;
      swpb_pkg::ST_UPD:  state_nxt = swpb_pkg::ST_MUL;
      swpb_pkg::ST_MUL:  state_nxt = swpb_pkg::ST_DIV;
      swpb_pkg::ST_DIV:  state_nxt = swpb_pkg::ST_GRP;
      swpb_pkg::ST_GRP:  state_nxt = swpb_pkg::ST_OUT;
      swpb_pkg::ST_OUT:  if (out_free) state_nxt = swpb_pkg::ST_IDLE;
      default:           state_nxt = swpb_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ctl.upd     = 1'b0;
    ctl.del_en  = full;
    mul_en      = 1'b0;
    div_en      = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      swpb_pkg::ST_IDLE: in_ch.ready = 1'b1;
      swpb_pkg::ST_UPD:  ctl.upd = 1'b1;
      swpb_pkg::ST_MUL:  mul_en = 1'b1;
      swpb_pkg::ST_DIV:  div_en = 1'b1;
      swpb_pkg::ST_GRP:  ;
      swpb_pkg::ST_OUT:  out_load = out_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swpb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= swpb_pkg::BAND_RESET;
    end else if (cfg_ch.valid) begin
      band_r <= cfg_ch.band_percent;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.sample;
    end
  end

  // arrival ring: overwrite the oldest slot once full, else append
  assign slot_sum = {1'b0, oldest_r} + (IDX_W+1)'(cnt_r);
  assign wr_slot  = (slot_sum >= (IDX_W+1)'(WINDOW_DEPTH)) ?
                    IDX_W'(slot_sum - (IDX_W+1)'(WINDOW_DEPTH)) : IDX_W'(slot_sum);

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      ring_mem[full ? oldest_r : wr_slot] <= sample_r;
    end
    ov_r <= ring_mem[oldest_r];
  end

  always_comb begin
    oldest_nxt = oldest_r;
    cnt_nxt    = cnt_r;
    if (full) begin
      oldest_nxt = (oldest_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      cnt_r    <= '0;
    end else if (ctl.upd) begin
      oldest_r <= oldest_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // lower index = floor(count * band / 200)
  assign quot   = prod_r[PRD_W-1:swpb_pkg::DIV_PRE_SHIFT] * swpb_pkg::DIV_RECIP;
  assign lo_nxt = quot[swpb_pkg::DIV_SHIFT +: IDX_W];

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PRD_W'(cnt_r) * PRD_W'(band_r);
    end
    if (div_en) begin
      lo_r <= lo_nxt;
      hi_r <= IDX_W'(cnt_r - CNT_W'(1) - CNT_W'(lo_nxt));
    end
  end

  swpb_chain #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .ins_val (sample_r),
    .old_val (ov_r),
    .lo_idx  (lo_r),
    .hi_idx  (hi_r),
    .lo_val  (lo_val),
    .hi_val  (hi_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.lower_bound <= lo_val;
      out_ch.upper_bound <= hi_val;
      out_ch.fill_count  <= cnt_r;
      out_ch.window_full <= full;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// ----- hdl/swpb_cell.sv -----
module swpb_cell #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swpb_pkg::swpb_ctl_t    ctl,
  input  logic [SAMPLE_BITS-1:0] ins_val,
  input  logic [SAMPLE_BITS-1:0] old_val,
  input  logic [SAMPLE_BITS-1:0] nxt_val,
  input  logic                   nxt_vld,
  input  logic [SAMPLE_BITS-1:0] prv_bval,
  input  logic                   prv_bvld,
  input  logic                   prv_gt,
  input  logic                   sel_lo,
  input  logic                   sel_hi,
  output logic [SAMPLE_BITS-1:0] val,
  output logic                   vld,
  output logic [SAMPLE_BITS-1:0] bval,
  output logic                   bvld,
  output logic                   gt,
  output logic [SAMPLE_BITS-1:0] lo_part,
  output logic [SAMPLE_BITS-1:0] hi_part
);

  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic                   vld_r, vld_nxt;
  logic                   del_le;

  // empty cells sort above every sample
  assign del_le = ctl.del_en && (!vld_r || (val_r >= old_val));
  assign bval   = del_le ? nxt_val : val_r;
  assign bvld   = del_le ? nxt_vld : vld_r;
  assign gt     = !bvld || (bval > ins_val);

  always_comb begin
    if (gt && prv_gt) begin
      val_nxt = prv_bval;
      vld_nxt = prv_bvld;
    end else if (gt) begin
      val_nxt = ins_val;
      vld_nxt = 1'b1;
    end else begin
      val_nxt = bval;
      vld_nxt = bvld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.upd) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      val_r <= val_nxt;
    end
  end

  assign val     = val_r;
  assign vld     = vld_r;
  assign lo_part = sel_lo ? val_r : '0;
  assign hi_part = sel_hi ? val_r : '0;

endmodule

// ----- hdl/swpb_chain.sv -----
module swpb_chain #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 10,
  parameter int IDX_W        = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swpb_pkg::swpb_ctl_t    ctl,
  input  logic [SAMPLE_BITS-1:0] ins_val,
  input  logic [SAMPLE_BITS-1:0] old_val,
  input  logic [IDX_W-1:0]       lo_idx,
  input  logic [IDX_W-1:0]       hi_idx,
  output logic [SAMPLE_BITS-1:0] lo_val,
  output logic [SAMPLE_BITS-1:0] hi_val
);

  localparam int GRP  = 8;
  localparam int NGRP = (WINDOW_DEPTH + GRP - 1) / GRP;

  logic [SAMPLE_BITS-1:0] val     [WINDOW_DEPTH];
  logic                   vld     [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] bval    [WINDOW_DEPTH];
  logic                   bvld    [WINDOW_DEPTH];
  logic                   gt      [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] lo_part [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] hi_part [WINDOW_DEPTH];

  logic [SAMPLE_BITS-1:0] grp_lo   [NGRP];
  logic [SAMPLE_BITS-1:0] grp_hi   [NGRP];
  logic [SAMPLE_BITS-1:0] grp_lo_r [NGRP];
  logic [SAMPLE_BITS-1:0] grp_hi_r [NGRP];

  for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cell
    logic [SAMPLE_BITS-1:0] nv;
    logic                   nvl;
    logic [SAMPLE_BITS-1:0] pbv;
    logic                   pbl;
    logic                   pgt;

    if (j == WINDOW_DEPTH - 1) begin : g_top
      assign nv  = '0;
      assign nvl = 1'b0;
    end else begin : g_mid
      assign nv  = val[j+1];
      assign nvl = vld[j+1];
    end

    if (j == 0) begin : g_bot
      assign pbv = '0;
      assign pbl = 1'b0;
      assign pgt = 1'b0;
    end else begin : g_up
      assign pbv = bval[j-1];
      assign pbl = bvld[j-1];
      assign pgt = gt[j-1];
    end

    swpb_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ins_val  (ins_val),
      .old_val  (old_val),
      .nxt_val  (nv),
      .nxt_vld  (nvl),
      .prv_bval (pbv),
      .prv_bvld (pbl),
      .prv_gt   (pgt),
      .sel_lo   (lo_idx == IDX_W'(j)),
      .sel_hi   (hi_idx == IDX_W'(j)),
      .val      (val[j]),
      .vld      (vld[j]),
      .bval     (bval[j]),
      .bvld     (bvld[j]),
      .gt       (gt[j]),
      .lo_part  (lo_part[j]),
      .hi_part  (hi_part[j])
    );
  end

  // first level of the readout tree: one OR per group of eight cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_lo[g] = '0;
      grp_hi[g] = '0;
      for (int m = 0; m < GRP; m++) begin
        if (g * GRP + m < WINDOW_DEPTH) begin
          grp_lo[g] = grp_lo[g] | lo_part[g*GRP+m];
          grp_hi[g] = grp_hi[g] | hi_part[g*GRP+m];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_lo_r <= grp_lo;
    grp_hi_r <= grp_hi;
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      lo_val = lo_val | grp_lo_r[g];
      hi_val = hi_val | grp_hi_r[g];
    end
  end

endmodule
